>>> rtl/cftad_pkg.sv
// ----------------------------------------------------------------------------
// cftad_pkg
// Shared types and constants for the CAN frame timing anomaly detector.
// ----------------------------------------------------------------------------
package cftad_pkg;

  localparam logic [1:0] OpLoad  = 2'd0;
  localparam logic [1:0] OpFrame = 2'd1;
  localparam logic [1:0] OpCheck = 2'd2;

  localparam logic [3:0] FlagUnknown = 4'b0001;
  localparam logic [3:0] FlagLength  = 4'b0010;
  localparam logic [3:0] FlagEarly   = 4'b0100;
  localparam logic [3:0] FlagMissing = 4'b1000;

  localparam logic KindVerdict = 1'b0;
  localparam logic KindMissing = 1'b1;

  localparam int MaxReports = 16;
  localparam int CntW       = $clog2(MaxReports + 1);

  typedef struct packed {
    logic [28:0] id;
    logic [3:0]  len;
    logic [31:0] period;
    logic [31:0] tol;
  } profile_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRD,
    ST_FCHK,
    ST_GAP,
    ST_MING,
    ST_FCMP,
    ST_TRD,
    ST_TCHK,
    ST_ADD1,
    ST_ADD2,
    ST_TCMP,
    ST_TPUSH,
    ST_EMIT
  } state_e;

endpackage

>>> rtl/can_frame_timing_anomaly_detector.sv
// ----------------------------------------------------------------------------
// can_frame_timing_anomaly_detector
// Profile table with frame verdicts and timeout scans on one shared adder.
// ----------------------------------------------------------------------------
// A frame request walks the profile table from slot 0, each slot a registered
// table read, then an identifier compare; a hit adds the gap, minimum gap and
// compare steps and hands the verdict to the output register once free. A
// timeout check walks the slots until the last one or MaxReports reports: a
// slot that cannot time out takes a read and a check, one that can adds the
// period and tolerance sums and a compare, and each report is handed over
// once the output is free. The steps come from the single 64-bit adder shared
// by all time arithmetic and the profile table's one read port. The input is
// stalled while a request is worked on; a finished result waits in the output
// register without blocking the next request.
module can_frame_timing_anomaly_detector import cftad_pkg::*; #(
  parameter int PROFILE_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  slot_i,
  input  logic [28:0] message_id_i,
  input  logic [3:0]  length_code_i,
  input  logic [63:0] time_us_i,
  input  logic [31:0] period_us_i,
  input  logic [31:0] tolerance_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        report_kind_o,
  output logic [28:0] report_id_o,
  output logic [3:0]  anomaly_flags_o,
  output logic [63:0] report_time_us_o,
  output logic        last_of_run_o
);

  localparam int IdxW = (PROFILE_SLOTS > 1) ? $clog2(PROFILE_SLOTS) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(PROFILE_SLOTS - 1);

  state_e st_q, st_d;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q;
  logic [28:0]     id_q;
  logic [3:0]      len_q;
  logic [63:0]     t_q;
  logic [63:0]     acc_q;
  logic [31:0]     mg_q;

  logic [PROFILE_SLOTS-1:0] valid_q, seen_q, miss_q;

  profile_t    prof_mem [PROFILE_SLOTS];
  logic [63:0] time_mem [PROFILE_SLOTS];
  profile_t    rd_prof_q;
  logic [63:0] rd_time_q;

  logic        pend_valid_q;
  logic        pend_kind_q;
  logic [28:0] pend_id_q;
  logic [3:0]  pend_flags_q;

  logic        out_valid_q;
  logic        out_kind_q;
  logic [28:0] out_id_q;
  logic [3:0]  out_flags_q;
  logic [63:0] out_time_q;
  logic        out_last_q;

  logic        in_fire, out_free, prof_we;
  logic [IdxW-1:0] wr_slot;
  logic        idx_last, id_match, elig, late, cap_first;
  logic [3:0]  frame_flags;

  logic [63:0] op_a, op_b;
  logic        op_cin;
  logic [64:0] sum;

  logic        acc_ld, mg_ld, time_we, frame_mark, miss_set, cnt_inc;
  logic        pend_ld, pend_clr, push, push_last;
  logic        pend_kind_d;
  logic [28:0] pend_id_d;
  logic [3:0]  pend_flags_d;

  assign in_stall_o = (st_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign prof_we    = in_fire && (operation_i == OpLoad) && (32'(slot_i) < PROFILE_SLOTS);
  assign wr_slot    = IdxW'(slot_i);

  assign idx_last  = (idx_q == IdxLast);
  assign id_match  = valid_q[idx_q] && (rd_prof_q.id == id_q);
  assign elig      = valid_q[idx_q] && (rd_prof_q.period != '0) && seen_q[idx_q]
                     && !miss_q[idx_q];
  assign late      = sum[64];
  assign cap_first = ((cnt_q + CntW'(1)) == CntW'(MaxReports));

  assign frame_flags = ((len_q != rd_prof_q.len) ? FlagLength : 4'b0000)
                     | (((rd_prof_q.period != '0) && seen_q[idx_q] && !sum[64])
                        ? FlagEarly : 4'b0000);

  // shared adder operand select
  always_comb begin
    op_a   = t_q;
    op_b   = '0;
    op_cin = 1'b0;
    case (st_q)
      ST_GAP: begin
        op_b   = ~rd_time_q;
        op_cin = 1'b1;
      end
      ST_MING: begin
        op_a   = {32'h0, rd_prof_q.period};
        op_b   = {32'h0, ~rd_prof_q.tol};
        op_cin = 1'b1;
      end
      ST_FCMP: begin
        op_a   = acc_q;
        op_b   = {32'hFFFF_FFFF, ~mg_q};
        op_cin = 1'b1;
      end
      ST_ADD1: begin
        op_a = rd_time_q;
        op_b = {32'h0, rd_prof_q.period};
      end
      ST_ADD2: begin
        op_a = acc_q;
        op_b = {32'h0, rd_prof_q.tol};
      end
      ST_TCMP: begin
        op_b = ~acc_q;
      end
      default: begin
        op_b = '0;
      end
    endcase
  end

  assign sum = {1'b0, op_a} + {1'b0, op_b} + {64'h0, op_cin};

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_fire && operation_i == OpFrame) st_d = ST_FRD;
        else if (in_fire && operation_i == OpCheck) st_d = ST_TRD;
      end
      ST_FRD:  st_d = ST_FCHK;
      ST_FCHK: begin
        if (id_match) st_d = ST_GAP;
        else if (idx_last) st_d = ST_EMIT;
        else st_d = ST_FRD;
      end
      ST_GAP:  st_d = ST_MING;
      ST_MING: st_d = ST_FCMP;
      ST_FCMP: st_d = ST_EMIT;
      ST_TRD:  st_d = ST_TCHK;
      ST_TCHK: begin
        if (elig) st_d = ST_ADD1;
        else if (idx_last) st_d = pend_valid_q ? ST_EMIT : ST_IDLE;
        else st_d = ST_TRD;
      end
      ST_ADD1: st_d = ST_ADD2;
      ST_ADD2: st_d = ST_TCMP;
      ST_TCMP: begin
        if (late) begin
          if (pend_valid_q) st_d = ST_TPUSH;
          else if (cap_first || idx_last) st_d = ST_EMIT;
          else st_d = ST_TRD;
        end else if (idx_last) begin
          st_d = pend_valid_q ? ST_EMIT : ST_IDLE;
        end else begin
          st_d = ST_TRD;
        end
      end
      ST_TPUSH: begin
        if (out_free) begin
          if (cnt_q == CntW'(MaxReports) || idx_last) st_d = ST_EMIT;
          else st_d = ST_TRD;
        end
      end
      ST_EMIT: begin
        if (out_free) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    acc_ld       = 1'b0;
    mg_ld        = 1'b0;
    time_we      = 1'b0;
    frame_mark   = 1'b0;
    miss_set     = 1'b0;
    cnt_inc      = 1'b0;
    pend_ld      = 1'b0;
    pend_clr     = 1'b0;
    push         = 1'b0;
    push_last    = 1'b0;
    pend_kind_d  = KindMissing;
    pend_id_d    = rd_prof_q.id;
    pend_flags_d = FlagMissing;
    case (st_q)
      ST_FCHK: begin
        if (!id_match && idx_last) begin
          pend_ld      = 1'b1;
          pend_kind_d  = KindVerdict;
          pend_id_d    = id_q;
          pend_flags_d = FlagUnknown;
        end
      end
      ST_GAP:  acc_ld = 1'b1;
      ST_MING: mg_ld  = 1'b1;
      ST_FCMP: begin
        time_we      = 1'b1;
        frame_mark   = 1'b1;
        pend_ld      = 1'b1;
        pend_kind_d  = KindVerdict;
        pend_id_d    = id_q;
        pend_flags_d = frame_flags;
      end
      ST_ADD1: acc_ld = 1'b1;
      ST_ADD2: acc_ld = 1'b1;
      ST_TCMP: begin
        if (late) begin
          miss_set = 1'b1;
          cnt_inc  = 1'b1;
          pend_ld  = !pend_valid_q;
        end
      end
      ST_TPUSH: begin
        if (out_free) begin
          push    = 1'b1;
          pend_ld = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          pend_clr  = 1'b1;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (st_q == ST_IDLE) idx_d = '0;
    else if (st_d == ST_FRD || st_d == ST_TRD) idx_d = idx_q + IdxW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      idx_q        <= '0;
      cnt_q        <= '0;
      valid_q      <= '0;
      seen_q       <= '0;
      miss_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
      if (st_q == ST_IDLE) cnt_q <= '0;
      else if (cnt_inc) cnt_q <= cnt_q + CntW'(1);
      if (prof_we) begin
        valid_q[wr_slot] <= 1'b1;
        seen_q[wr_slot]  <= 1'b0;
        miss_q[wr_slot]  <= 1'b0;
      end
      if (frame_mark) begin
        seen_q[idx_q] <= 1'b1;
        miss_q[idx_q] <= 1'b0;
      end
      if (miss_set) miss_q[idx_q] <= 1'b1;
      if (pend_ld) pend_valid_q <= 1'b1;
      else if (pend_clr) pend_valid_q <= 1'b0;
      if (push) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      id_q  <= message_id_i;
      len_q <= length_code_i;
      t_q   <= time_us_i;
    end
    if (acc_ld) acc_q <= sum[63:0];
    if (mg_ld) mg_q <= sum[32] ? sum[31:0] : '0;
    if (pend_ld) begin
      pend_kind_q  <= pend_kind_d;
      pend_id_q    <= pend_id_d;
      pend_flags_q <= pend_flags_d;
    end
    if (push) begin
      out_kind_q  <= pend_kind_q;
      out_id_q    <= pend_id_q;
      out_flags_q <= pend_flags_q;
      out_time_q  <= t_q;
      out_last_q  <= push_last;
    end
  end

  // profile and timestamp tables
  always_ff @(posedge clk_i) begin
    if (prof_we) begin
      prof_mem[wr_slot] <= '{id: message_id_i, len: length_code_i,
                             period: period_us_i, tol: tolerance_us_i};
    end
    rd_prof_q <= prof_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (time_we) time_mem[idx_q] <= t_q;
    rd_time_q <= time_mem[idx_q];
  end

  assign out_valid_o      = out_valid_q;
  assign report_kind_o    = out_kind_q;
  assign report_id_o      = out_id_q;
  assign anomaly_flags_o  = out_flags_q;
  assign report_time_us_o = out_time_q;
  assign last_of_run_o    = out_last_q;

endmodule
